@@ rtl/core/drm_pkg.sv @@
// drm_pkg: shared types and codes of the dirty rectangle merge table
`timescale 1ns / 1ps

package drm_pkg;

    localparam int COORD_W    = 12;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int TABLE_DEPTH = 16;

    localparam logic [COORD_W-1:0] SIZE_MAX = {COORD_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COORD_W-1:0]        w;
        logic [COORD_W-1:0]        h;
    } t_rect;

endpackage

@@ rtl/core/drm_if.sv @@
// drm_in_if and drm_out_if: valid/ready channels of the merge table
`timescale 1ns / 1ps

interface drm_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [drm_pkg::COORD_W-1:0] pos_x;
    logic signed [drm_pkg::COORD_W-1:0] pos_y;
    logic [drm_pkg::COORD_W-1:0]        size_w;
    logic [drm_pkg::COORD_W-1:0]        size_h;

    modport source (output valid, kind, pos_x, pos_y, size_w, size_h, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface drm_out_if;
    logic                                valid;
    logic                                ready;
    logic [drm_pkg::STATUS_W-1:0]        status;
    logic [drm_pkg::SLOT_W-1:0]          slot;
    logic signed [drm_pkg::COORD_W-1:0] out_x;
    logic signed [drm_pkg::COORD_W-1:0] out_y;
    logic [drm_pkg::COORD_W-1:0]        out_w;
    logic [drm_pkg::COORD_W-1:0]        out_h;
    logic                                last;

    modport source (output valid, status, slot, out_x, out_y, out_w, out_h, last,
                    input ready);
    modport sink   (input valid, status, slot, out_x, out_y, out_w, out_h, last,
                    output ready);
endinterface

@@ rtl/core/drm_rect_unit.sv @@
// drm_rect_unit: shared overlap test and bounding box merge of two rectangles
`timescale 1ns / 1ps

module drm_rect_unit (
    input  drm_pkg::t_rect i_stored,
    input  drm_pkg::t_rect i_new,
    output logic           o_touch,
    output drm_pkg::t_rect o_merged
);

    localparam int EXT_W = drm_pkg::COORD_W + 2;

    logic signed [EXT_W-1:0] s_x, s_y, s_r, s_b;
    logic signed [EXT_W-1:0] a_x, a_y, a_r, a_b;
    logic signed [EXT_W-1:0] x1, y1, x2, y2, dw, dh;

    always_comb begin
        s_x = {{2{i_stored.x[drm_pkg::COORD_W-1]}}, i_stored.x};
        s_y = {{2{i_stored.y[drm_pkg::COORD_W-1]}}, i_stored.y};
        a_x = {{2{i_new.x[drm_pkg::COORD_W-1]}}, i_new.x};
        a_y = {{2{i_new.y[drm_pkg::COORD_W-1]}}, i_new.y};
        s_r = s_x + {2'b00, i_stored.w};
        s_b = s_y + {2'b00, i_stored.h};
        a_r = a_x + {2'b00, i_new.w};
        a_b = a_y + {2'b00, i_new.h};

        o_touch = !((s_r < a_x) || (a_r < s_x) || (s_b < a_y) || (a_b < s_y));

        x1 = (s_x < a_x) ? s_x : a_x;
        y1 = (s_y < a_y) ? s_y : a_y;
        x2 = (s_r > a_r) ? s_r : a_r;
        y2 = (s_b > a_b) ? s_b : a_b;
        dw = x2 - x1;
        dh = y2 - y1;

        o_merged.x = x1[drm_pkg::COORD_W-1:0];
        o_merged.y = y1[drm_pkg::COORD_W-1:0];
        o_merged.w = (dw > EXT_W'(drm_pkg::SIZE_MAX)) ? drm_pkg::SIZE_MAX
                                                     : dw[drm_pkg::COORD_W-1:0];
        o_merged.h = (dh > EXT_W'(drm_pkg::SIZE_MAX)) ? drm_pkg::SIZE_MAX
                                                     : dh[drm_pkg::COORD_W-1:0];
    end

endmodule

@@ rtl/core/dirty_rect_merge_table.sv @@
// dirty_rect_merge_table: table of damage rectangles with merge, append and flush
//
// Input channel i_in carries one item per transfer: kind selects add or flush,
// pos_x/pos_y/size_w/size_h give the rectangle of an add. Output channel o_out
// carries result items; last marks the final result of an input item.
// An add walks the stored slots one per cycle through a single overlap/merge
// unit fed by the registered read port of the slot memory and yields one
// result: merged, appended or dropped when full.
// A flush reads the slots in order and emits one listed rectangle per slot,
// one cycle each when o_out keeps up, or a single empty status, then clears
// the count. i_in is ready only while the block is idle; the result register
// lets a new item be accepted while the previous result still waits.
// When o_out stalls, the sequencer holds its place until the result is taken.
// Reset clears the entry count and the control state; the slot memory itself
// is not cleared since only slots below the count are ever read.
`timescale 1ns / 1ps

module dirty_rect_merge_table #(
    parameter int MAX_RECTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drm_in_if.sink     i_in,
    drm_out_if.source  o_out
);

    localparam int CAP   = (MAX_RECTS < drm_pkg::TABLE_DEPTH) ? MAX_RECTS
                                                               : drm_pkg::TABLE_DEPTH;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W = $clog2(CAP + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TEST  = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_LIST  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    drm_pkg::t_rect   r_new, n_new;
    drm_pkg::t_rect   r_rd;
    drm_pkg::t_rect   r_mem [CAP];

    logic                         r_ov, n_ov;
    logic [drm_pkg::STATUS_W-1:0] r_status, n_status;
    logic [drm_pkg::SLOT_W-1:0]   r_slot, n_slot;
    drm_pkg::t_rect               r_res, n_res;
    logic                         r_last, n_last;

    logic             w_en;
    logic [IDX_W-1:0] w_addr;
    drm_pkg::t_rect   w_data;

    logic             touch;
    drm_pkg::t_rect   merged;
    logic             out_free;
    logic             idx_last;
    logic             in_take;

    drm_rect_unit u_rect (
        .i_stored (r_rd),
        .i_new    (r_new),
        .o_touch  (touch),
        .o_merged (merged)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign in_take      = i_in.valid && i_in.ready;
    assign out_free     = !r_ov || o_out.ready;
    assign idx_last     = ((CNT_W'(r_idx) + 1'b1) == r_count);

    assign o_out.valid  = r_ov;
    assign o_out.status = r_status;
    assign o_out.slot   = r_slot;
    assign o_out.out_x  = r_res.x;
    assign o_out.out_y  = r_res.y;
    assign o_out.out_w  = r_res.w;
    assign o_out.out_h  = r_res.h;
    assign o_out.last   = r_last;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_new    = r_new;
        n_ov     = r_ov && !o_out.ready;
        n_status = r_status;
        n_slot   = r_slot;
        n_res    = r_res;
        n_last   = r_last;
        w_en     = 1'b0;
        w_addr   = r_idx;
        w_data   = r_new;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_new.x = i_in.pos_x;
                    n_new.y = i_in.pos_y;
                    n_new.w = i_in.size_w;
                    n_new.h = i_in.size_h;
                    n_idx   = '0;
                    if (i_in.kind == drm_pkg::KIND_FLUSH) begin
                        n_state = (r_count == '0) ? S_EMPTY : S_LIST;
                    end else begin
                        n_state = (r_count == '0) ? S_PLACE : S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (touch) begin
                    n_state = S_MERGE;
                end else if (idx_last) begin
                    n_state = S_PLACE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MERGE: begin
                if (out_free) begin
                    w_en     = 1'b1;
                    w_data   = merged;
                    n_ov     = 1'b1;
                    n_status = drm_pkg::ST_MERGED;
                    n_slot   = drm_pkg::SLOT_W'(r_idx);
                    n_res    = merged;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PLACE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_res   = r_new;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                    if (r_count < CNT_W'(CAP)) begin
                        w_en     = 1'b1;
                        w_addr   = r_count[IDX_W-1:0];
                        n_count  = r_count + 1'b1;
                        n_status = drm_pkg::ST_APPENDED;
                        n_slot   = drm_pkg::SLOT_W'(r_count);
                    end else begin
                        n_status = drm_pkg::ST_DROPPED;
                        n_slot   = '0;
                    end
                end
            end
            S_LIST: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_status = drm_pkg::ST_LISTED;
                    n_slot   = drm_pkg::SLOT_W'(r_idx);
                    n_res    = r_rd;
                    n_last   = idx_last;
                    if (idx_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_status = drm_pkg::ST_EMPTY;
                    n_slot   = '0;
                    n_res    = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_res    <= n_res;
        r_last   <= n_last;
    end

    // slot memory: one write port, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[n_idx];
    end

endmodule

@@ rtl/core/drm_checker.sv @@
// drm_checker: port level assertions of the merge table, bound to the top level
`timescale 1ns / 1ps

module drm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [drm_pkg::STATUS_W-1:0] i_status,
    input logic [drm_pkg::SLOT_W-1:0]   i_slot,
    input drm_pkg::t_rect               i_res,
    input logic                         i_last
);

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_slot) && $stable(i_res) && $stable(i_last))
        else $error("stalled result changed");

    // block is busy right after an accepted item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a transfer");

    // add results are single and carry last
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == drm_pkg::ST_MERGED
            || i_status == drm_pkg::ST_APPENDED || i_status == drm_pkg::ST_DROPPED)
        |-> i_last)
        else $error("add result without last");

    // empty status is a single zero result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == drm_pkg::ST_EMPTY
        |-> i_last && i_slot == '0 && i_res == '0)
        else $error("empty status malformed");

endmodule

bind dirty_rect_merge_table drm_checker u_drm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_slot      (o_out.slot),
    .i_res       ({o_out.out_x, o_out.out_y, o_out.out_w, o_out.out_h}),
    .i_last      (o_out.last)
);
